@@ design/swst_pkg.sv @@
// ----------------------------------------------------------------------------
// swst_pkg: shared types and constants for the sample window statistics block
// Sample and result widths, scaling constants, back-end state encoding and
// the status groups passed between the queue, the back end and the top level.
// ----------------------------------------------------------------------------
package swst_pkg;

   // ADC sample width and full-scale code
   localparam int SAMPLE_BITS  = 10;
   localparam int FULL_SCALE   = (2 ** SAMPLE_BITS) - 1;

   // Millivolt scaling against a 2.5 V reference
   localparam int REF_MV       = 2500;
   localparam int MV_W         = 12;
   localparam int PROD_W       = 22;   // holds FULL_SCALE * REF_MV
   localparam int EST_W        = PROD_W + 1 - SAMPLE_BITS;

   // Window length register
   localparam int CFG_W        = 8;
   localparam int WINDOW_RESET = 100;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_SCALE,
      BK_ESTIMATE,
      BK_CORRECT
   } back_state_type;

   typedef struct packed {
      logic correcting;
   } back_status_type;

   typedef struct packed {
      logic full;
   } queue_status_type;

endpackage

@@ design/sample_window_statistics.sv @@
// ----------------------------------------------------------------------------
// sample_window_statistics: windowed min / max / mean of an ADC stream
// Reports maximum, minimum, peak-to-peak, mean and mean in millivolts once
// per window of csr-programmed length.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_sample
//   rsp     | out       | rsp_valid / rsp_ready | rsp_peak_high .. rsp_mean_millivolts
//   csr     | in        | csr_write_enable      | csr_write_data (window length)
//
// Samples are taken one per cycle; req_ready drops only on a window's last
// sample while the two-entry totals queue is full.
// The back end works each window through the sum / count divide, one quotient
// bit per cycle, then the scale, estimate and correct steps; SUM_W is 17 at
// MAX_WINDOW = 128, and windows shorter than the back end's pass are limited by it.
// A result waits in the output register while the next window is worked on.
// Synchronous reset; no clearing pass. Window length resets to 100.
// ----------------------------------------------------------------------------
module sample_window_statistics #(
   parameter int MAX_WINDOW = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [swst_pkg::SAMPLE_BITS-1:0]    req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [swst_pkg::SAMPLE_BITS-1:0]    rsp_peak_high,
   output logic [swst_pkg::SAMPLE_BITS-1:0]    rsp_peak_low,
   output logic [swst_pkg::SAMPLE_BITS-1:0]    rsp_peak_to_peak,
   output logic [swst_pkg::SAMPLE_BITS-1:0]    rsp_mean_counts,
   output logic [swst_pkg::MV_W-1:0]           rsp_mean_millivolts,
   input  logic                                csr_write_enable,
   input  logic [swst_pkg::CFG_W-1:0]          csr_write_data
);

   localparam int SB    = swst_pkg::SAMPLE_BITS;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = $clog2(MAX_WINDOW * swst_pkg::FULL_SCALE + 1);
   localparam int REC_W = 2 * SB + SUM_W + CNT_W;

   logic                        push_valid;
   logic                        push_ready;
   swst_pkg::sample_type        push_high;
   swst_pkg::sample_type        push_low;
   logic [SUM_W-1:0]            push_sum;
   logic [CNT_W-1:0]            push_count;
   logic                        pop_valid;
   logic                        pop_ready;
   logic [REC_W-1:0]            pop_data;
   swst_pkg::queue_status_type  q_status;
   swst_pkg::back_status_type   bk_status;

   swst_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_high        (push_high),
      .push_low         (push_low),
      .push_sum         (push_sum),
      .push_count       (push_count)
   );

   swst_queue #(
      .WIDTH (REC_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_high, push_low, push_sum, push_count}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   swst_back #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_high            (pop_data[REC_W-1 -: SB]),
      .pop_low             (pop_data[REC_W-SB-1 -: SB]),
      .pop_sum             (pop_data[CNT_W +: SUM_W]),
      .pop_count           (pop_data[CNT_W-1:0]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_peak_high       (rsp_peak_high),
      .rsp_peak_low        (rsp_peak_low),
      .rsp_peak_to_peak    (rsp_peak_to_peak),
      .rsp_mean_counts     (rsp_mean_counts),
      .rsp_mean_millivolts (rsp_mean_millivolts),
      .status              (bk_status)
   );

`ifndef NO_ASSERTIONS
   // A result appears only out of the correction step
   a_rsp_from_correct : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bk_status.correcting))
      else $error("result raised without a finished correction step");

   // Input stalls only when the totals queue is full
   a_stall_on_full : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |-> q_status.full)
      else $error("sample stalled while the queue had room");

   // Peak fields agree with each other
   a_peak_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_low <= rsp_peak_high) &&
                    (rsp_peak_to_peak == SB'(rsp_peak_high - rsp_peak_low)))
      else $error("peak fields inconsistent");

   // Scaled mean never exceeds the reference
   a_mv_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mean_millivolts <= swst_pkg::MV_W'(swst_pkg::REF_MV)))
      else $error("millivolt result above reference");
`endif

endmodule

@@ design/swst_front.sv @@
// ----------------------------------------------------------------------------
// swst_front: window accumulator
// Holds the window length register, takes one sample per item and keeps the
// running maximum, minimum, sum and count. The item that closes the window
// pushes its totals into the queue and restarts the window.
// ----------------------------------------------------------------------------
module swst_front #(
   parameter int MAX_WINDOW = 128,
   parameter int CNT_W      = 8,
   parameter int SUM_W      = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  swst_pkg::sample_type               req_sample,
   input  logic                               csr_write_enable,
   input  logic [swst_pkg::CFG_W-1:0]         csr_write_data,
   output logic                               push_valid,
   input  logic                               push_ready,
   output swst_pkg::sample_type               push_high,
   output swst_pkg::sample_type               push_low,
   output logic [SUM_W-1:0]                   push_sum,
   output logic [CNT_W-1:0]                   push_count
);

   localparam int CMP_W     = (CNT_W > swst_pkg::CFG_W) ? CNT_W : swst_pkg::CFG_W;
   localparam int LEN_RESET = (swst_pkg::WINDOW_RESET > MAX_WINDOW) ?
                              MAX_WINDOW : swst_pkg::WINDOW_RESET;

   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   swst_pkg::sample_type high_ff, high_in;
   swst_pkg::sample_type low_ff, low_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;

   logic [CMP_W-1:0]     wr_ext;
   logic [CNT_W:0]       seen_inc;
   logic                 first;
   logic                 close;
   logic                 accept;

   // Clamp the written length into 1..MAX_WINDOW
   always_comb begin
      wr_ext = CMP_W'(csr_write_data);
      len_in = len_ff;
      if (csr_write_enable) begin
         if (wr_ext == '0) begin
            len_in = CNT_W'(1);
         end else if (wr_ext > CMP_W'(MAX_WINDOW)) begin
            len_in = CNT_W'(MAX_WINDOW);
         end else begin
            len_in = wr_ext[CNT_W-1:0];
         end
      end
   end

   // Window end depends on the count only, never on the sample
   assign seen_inc  = {1'b0, seen_ff} + (CNT_W+1)'(1);
   assign close     = seen_inc >= {1'b0, len_ff};
   assign first     = (seen_ff == '0);
   assign req_ready = !close || push_ready;
   assign accept    = req_valid && req_ready;

   // Fold the new sample into the running totals
   always_comb begin
      high_in = high_ff;
      low_in  = low_ff;
      sum_in  = sum_ff;
      if (first || (req_sample > high_ff)) begin
         high_in = req_sample;
      end
      if (first || (req_sample < low_ff)) begin
         low_in = req_sample;
      end
      if (first) begin
         sum_in = SUM_W'(req_sample);
      end else begin
         sum_in = sum_ff + SUM_W'(req_sample);
      end
   end

   // Advance or restart the window count
   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (close) begin
            seen_in = '0;
         end else begin
            seen_in = seen_inc[CNT_W-1:0];
         end
      end
   end

   assign push_valid = req_valid && close;
   assign push_high  = high_in;
   assign push_low   = low_in;
   assign push_sum   = sum_in;
   assign push_count = seen_inc[CNT_W-1:0];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= CNT_W'(LEN_RESET);
         seen_ff <= '0;
      end else begin
         len_ff  <= len_in;
         seen_ff <= seen_in;
      end
   end

   // Running totals
   always_ff @(posedge clock) begin
      if (accept && !close) begin
         high_ff <= high_in;
         low_ff  <= low_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

@@ design/swst_queue.sv @@
// ----------------------------------------------------------------------------
// swst_queue: two-entry queue of finished window totals
// Lets the accumulator close a new window while the back end is still
// dividing the previous one.
// ----------------------------------------------------------------------------
module swst_queue #(
   parameter int WIDTH = 45
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output logic [WIDTH-1:0]           pop_data,
   output swst_pkg::queue_status_type status
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready   = (level_ff != LVL_W'(DEPTH));
   assign pop_valid    = (level_ff != '0);
   assign pop_data     = entry_ff[rd_ptr_ff];
   assign do_push      = push_valid && push_ready;
   assign do_pop       = pop_valid && pop_ready;
   assign status.full  = !push_ready;

   // Move pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   level_in = level_ff + LVL_W'(1);
         2'b01:   level_in = level_ff - LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store pushed totals
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/swst_back.sv @@
// ----------------------------------------------------------------------------
// swst_back: statistics finisher
// Pops one window's totals, divides the sum by the count one quotient bit
// per cycle, scales the mean to millivolts and drops the result into the
// output register.
// ----------------------------------------------------------------------------
module swst_back #(
   parameter int CNT_W = 8,
   parameter int SUM_W = 17
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  swst_pkg::sample_type                pop_high,
   input  swst_pkg::sample_type                pop_low,
   input  logic [SUM_W-1:0]                    pop_sum,
   input  logic [CNT_W-1:0]                    pop_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output swst_pkg::sample_type                rsp_peak_high,
   output swst_pkg::sample_type                rsp_peak_low,
   output swst_pkg::sample_type                rsp_peak_to_peak,
   output swst_pkg::sample_type                rsp_mean_counts,
   output logic [swst_pkg::MV_W-1:0]           rsp_mean_millivolts,
   output swst_pkg::back_status_type           status
);

   localparam int SB     = swst_pkg::SAMPLE_BITS;
   localparam int PW     = swst_pkg::PROD_W;
   localparam int EW     = swst_pkg::EST_W;
   localparam int MW     = swst_pkg::MV_W;
   localparam int STEP_W = $clog2(SUM_W);

   swst_pkg::back_state_type state_ff, state_in;

   swst_pkg::sample_type high_ff, high_in;
   swst_pkg::sample_type low_ff, low_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [EW-1:0]        est_ff, est_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   swst_pkg::sample_type out_high_ff, out_high_in;
   swst_pkg::sample_type out_low_ff, out_low_in;
   swst_pkg::sample_type out_p2p_ff, out_p2p_in;
   swst_pkg::sample_type out_mean_ff, out_mean_in;
   logic [MW-1:0]        out_mv_ff, out_mv_in;

   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       trial_diff;
   logic                 trial_ge;
   logic [PW:0]          est_sum;
   logic [PW:0]          est_times_fs;
   logic [PW:0]          est_rem;
   logic [EW-1:0]        est_fixed;
   logic                 out_free;

   // Restoring divide step
   assign trial      = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   // Divide by 2^SB-1 as a reciprocal series, then one correction
   assign est_sum      = (PW+1)'(prod_ff) + (PW+1)'(prod_ff >> SB)
                       + (PW+1)'(prod_ff >> (2 * SB));
   assign est_times_fs = ((PW+1)'(est_ff) << SB) - (PW+1)'(est_ff);
   assign est_rem      = (PW+1)'(prod_ff) - est_times_fs;
   assign est_fixed    = (est_rem >= (PW+1)'(swst_pkg::FULL_SCALE)) ?
                         (est_ff + EW'(1)) : est_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      pop_ready    = 1'b0;
      high_in      = high_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_high_in  = out_high_ff;
      out_low_in   = out_low_ff;
      out_p2p_in   = out_p2p_ff;
      out_mean_in  = out_mean_ff;
      out_mv_in    = out_mv_ff;
      case (state_ff)
         swst_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               high_in  = pop_high;
               low_in   = pop_low;
               quo_in   = pop_sum;
               rem_in   = '0;
               den_in   = pop_count;
               step_in  = STEP_W'(SUM_W - 1);
               state_in = swst_pkg::BK_DIVIDE;
            end
         end
         swst_pkg::BK_DIVIDE: begin
            rem_in  = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = swst_pkg::BK_SCALE;
            end
         end
         swst_pkg::BK_SCALE: begin
            prod_in  = PW'(quo_ff[SB-1:0]) * PW'(swst_pkg::REF_MV);
            state_in = swst_pkg::BK_ESTIMATE;
         end
         swst_pkg::BK_ESTIMATE: begin
            est_in   = EW'(est_sum >> SB);
            state_in = swst_pkg::BK_CORRECT;
         end
         swst_pkg::BK_CORRECT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_high_in  = high_ff;
               out_low_in   = low_ff;
               out_p2p_in   = high_ff - low_ff;
               out_mean_in  = quo_ff[SB-1:0];
               out_mv_in    = est_fixed[MW-1:0];
               state_in     = swst_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = swst_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swst_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and output registers
   always_ff @(posedge clock) begin
      high_ff     <= high_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      est_ff      <= est_in;
      out_high_ff <= out_high_in;
      out_low_ff  <= out_low_in;
      out_p2p_ff  <= out_p2p_in;
      out_mean_ff <= out_mean_in;
      out_mv_ff   <= out_mv_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peak_high       = out_high_ff;
   assign rsp_peak_low        = out_low_ff;
   assign rsp_peak_to_peak    = out_p2p_ff;
   assign rsp_mean_counts     = out_mean_ff;
   assign rsp_mean_millivolts = out_mv_ff;
   assign status.correcting   = (state_ff == swst_pkg::BK_CORRECT);

endmodule

@@ tb/sv/tb_sample_window_statistics.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_window_statistics: self-checking bench for the window statistics
// Streams ADC samples through the block under random idle on both channels,
// predicts every window's max / min / peak-to-peak / mean / millivolt result
// and checks each result item field by field, in order.
// ----------------------------------------------------------------------------
module tb_sample_window_statistics;

   localparam int MAX_WINDOW     = 128;
   localparam int SUM_W          = 17;
   localparam int MAX_GAP        = 13;
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 400;

   typedef struct packed {
      swst_pkg::sample_type        peak_high;
      swst_pkg::sample_type        peak_low;
      swst_pkg::sample_type        peak_to_peak;
      swst_pkg::sample_type        mean_counts;
      logic [swst_pkg::MV_W-1:0]   mean_millivolts;
   } window_stats_type;

   typedef enum logic [1:0] {
      SPREAD_UNIFORM,
      SPREAD_RAILS,
      SPREAD_NARROW
   } sample_spread_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid;
   logic                        req_ready;
   swst_pkg::sample_type        req_sample;
   logic                        rsp_valid;
   logic                        rsp_ready;
   swst_pkg::sample_type        rsp_peak_high;
   swst_pkg::sample_type        rsp_peak_low;
   swst_pkg::sample_type        rsp_peak_to_peak;
   swst_pkg::sample_type        rsp_mean_counts;
   logic [swst_pkg::MV_W-1:0]   rsp_mean_millivolts;
   logic                        csr_write_enable;
   logic [swst_pkg::CFG_W-1:0]  csr_write_data;

   // window state tracked alongside the block
   logic [swst_pkg::CFG_W-1:0]  window_length = swst_pkg::CFG_W'(swst_pkg::WINDOW_RESET);
   logic [7:0]                  samples_seen  = '0;
   swst_pkg::sample_type        running_high  = '0;
   swst_pkg::sample_type        running_low   = '0;
   logic [SUM_W-1:0]            running_sum   = '0;

   window_stats_type   pending_windows[$];
   int                 errors          = 0;
   int                 hold_off_cycles = 0;
   bit                 steady_flow     = 1'b0;

   sample_window_statistics #(
      .MAX_WINDOW (MAX_WINDOW)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_peak_high       (rsp_peak_high),
      .rsp_peak_low        (rsp_peak_low),
      .rsp_peak_to_peak    (rsp_peak_to_peak),
      .rsp_mean_counts     (rsp_mean_counts),
      .rsp_mean_millivolts (rsp_mean_millivolts),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // fold one accepted sample into the window; queue a result when it closes
   task automatic accumulate_sample(input swst_pkg::sample_type s);
      int unsigned      window_end;
      int unsigned      mean;
      int unsigned      millivolts;
      window_stats_type stats;
      if (samples_seen == 0) begin
         running_high = s;
         running_low  = s;
         running_sum  = SUM_W'(s);
      end else begin
         if (s > running_high) running_high = s;
         if (s < running_low)  running_low  = s;
         running_sum = running_sum + SUM_W'(s);
      end
      samples_seen = samples_seen + 8'd1;

      // zero means one, anything above the maximum saturates
      if (window_length == 0)
         window_end = 1;
      else if (window_length > MAX_WINDOW)
         window_end = MAX_WINDOW;
      else
         window_end = window_length;
      if (samples_seen < window_end)
         return;

      mean       = running_sum / samples_seen;
      millivolts = (mean * swst_pkg::REF_MV) / swst_pkg::FULL_SCALE;
      stats.peak_high       = running_high;
      stats.peak_low        = running_low;
      stats.peak_to_peak    = running_high - running_low;
      stats.mean_counts     = swst_pkg::SAMPLE_BITS'(mean);
      stats.mean_millivolts = swst_pkg::MV_W'(millivolts);
      pending_windows.push_back(stats);

      samples_seen = '0;
      running_high = '0;
      running_low  = '0;
      running_sum  = '0;
   endtask

   // offer one sample after a random gap and hold it until accepted
   task automatic send_sample(input swst_pkg::sample_type s);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      accumulate_sample(s);
   endtask

   task automatic park_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // write the length once every pending result is out and the back end is quiet
   task automatic write_window_length(input logic [swst_pkg::CFG_W-1:0] len);
      park_request();
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      window_length = len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic swst_pkg::sample_type draw_sample(input sample_spread_type spread);
      case (spread)
         SPREAD_RAILS: begin
            case ($urandom_range(3, 0))
               0:       return '0;
               1:       return swst_pkg::sample_type'(1);
               2:       return swst_pkg::sample_type'(swst_pkg::FULL_SCALE - 1);
               default: return swst_pkg::sample_type'(swst_pkg::FULL_SCALE);
            endcase
         end
         SPREAD_NARROW: return swst_pkg::sample_type'($urandom_range(523, 500));
         default:       return swst_pkg::sample_type'($urandom_range(swst_pkg::FULL_SCALE, 0));
      endcase
   endfunction

   task automatic compare_field(input string field_name, input int unsigned expected_value,
                                input int unsigned actual_value);
      if (expected_value != actual_value) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field_name, expected_value, actual_value);
      end
   endtask

   task automatic check_result();
      window_stats_type want;
      if (pending_windows.size() == 0) begin
         errors++;
         $display("%0t: result item with no window pending, expected none, %s",
                  $time, "actual");
         $display("   %0d/%0d/%0d/%0d/%0d", rsp_peak_high, rsp_peak_low,
                  rsp_peak_to_peak, rsp_mean_counts, rsp_mean_millivolts);
         return;
      end
      want = pending_windows.pop_front();
      compare_field("peak_high", want.peak_high, rsp_peak_high);
      compare_field("peak_low", want.peak_low, rsp_peak_low);
      compare_field("peak_to_peak", want.peak_to_peak, rsp_peak_to_peak);
      compare_field("mean_counts", want.mean_counts, rsp_mean_counts);
      compare_field("mean_millivolts", want.mean_millivolts, rsp_mean_millivolts);
   endtask

   // default length of 100 after reset, rails placed at the start
   task automatic test_reset_window();
      send_sample(swst_pkg::sample_type'(swst_pkg::FULL_SCALE));
      send_sample('0);
      repeat (98) send_sample(draw_sample(SPREAD_UNIFORM));
   endtask

   // every sample closes its own window
   task automatic test_single_sample_windows();
      write_window_length(8'd1);
      send_sample('0);
      send_sample(swst_pkg::sample_type'(swst_pkg::FULL_SCALE));
      send_sample(10'h2AA);
      send_sample(10'h155);
   endtask

   // a zero length acts as one
   task automatic test_zero_length();
      write_window_length(8'd0);
      send_sample(10'd511);
      send_sample(10'd512);
   endtask

   // all-high, all-low and rail-to-rail pairs
   task automatic test_full_scale_pairs();
      write_window_length(8'd2);
      steady_flow = 1'b1;
      send_sample(swst_pkg::sample_type'(swst_pkg::FULL_SCALE));
      send_sample(swst_pkg::sample_type'(swst_pkg::FULL_SCALE));
      send_sample('0);
      send_sample('0);
      send_sample(swst_pkg::sample_type'(swst_pkg::FULL_SCALE));
      send_sample('0);
      steady_flow = 1'b0;
   endtask

   // move the end point while a window is partly filled
   task automatic test_length_moved_mid_window();
      // lowered below the samples already gathered
      write_window_length(8'd8);
      repeat (4) send_sample(draw_sample(SPREAD_UNIFORM));
      write_window_length(8'd3);
      send_sample(draw_sample(SPREAD_UNIFORM));
      // lowered so the next sample lands exactly on the end
      write_window_length(8'd10);
      repeat (4) send_sample(draw_sample(SPREAD_RAILS));
      write_window_length(8'd5);
      send_sample(draw_sample(SPREAD_RAILS));
      // raised while statistics are kept
      write_window_length(8'd3);
      repeat (2) send_sample(draw_sample(SPREAD_UNIFORM));
      write_window_length(8'd5);
      repeat (3) send_sample(draw_sample(SPREAD_UNIFORM));
   endtask

   // largest window, then lengths that saturate to it
   task automatic test_saturated_windows();
      write_window_length(8'(MAX_WINDOW));
      repeat (MAX_WINDOW) send_sample(swst_pkg::sample_type'(swst_pkg::FULL_SCALE));
      write_window_length(8'(MAX_WINDOW + 1));
      repeat (MAX_WINDOW) send_sample(draw_sample(SPREAD_UNIFORM));
      write_window_length(8'd255);
      repeat (MAX_WINDOW) send_sample(draw_sample(SPREAD_RAILS));
   endtask

   // stall the result side long enough that the input backs up
   task automatic test_output_backpressure();
      write_window_length(8'd1);
      hold_off_cycles = LONG_HOLD;
      steady_flow     = 1'b1;
      repeat (24) send_sample(draw_sample(SPREAD_UNIFORM));
      steady_flow     = 1'b0;
   endtask

   // random lengths and content; windows straddle length changes
   task automatic test_random_windows();
      logic [swst_pkg::CFG_W-1:0] len;
      sample_spread_type          spread;
      int                         count;
      for (int phase = 0; phase < 40; phase++) begin
         case ($urandom_range(9, 0))
            0:       len = swst_pkg::CFG_W'($urandom_range(255, 0));
            1:       len = 8'd1;
            default: len = swst_pkg::CFG_W'($urandom_range(16, 2));
         endcase
         write_window_length(len);
         spread      = sample_spread_type'($urandom_range(2, 0));
         steady_flow = ($urandom_range(3, 0) == 0);
         count       = $urandom_range(28, 4);
         repeat (count) send_sample(draw_sample(spread));
         steady_flow = 1'b0;
      end
   endtask

   // result side: random stalls, an optional long hold, check each item
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         stall = steady_flow ? 0 : $urandom_range(MAX_GAP, 0);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_result();
      end
   end

   // end the run when nothing moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_valid        = 1'b0;
      req_sample       = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_single_sample_windows();
      test_zero_length();
      test_full_scale_pairs();
      test_length_moved_mid_window();
      test_saturated_windows();
      test_output_backpressure();
      test_random_windows();

      // drain what is still in flight
      park_request();
      while (pending_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
